// File: src/shabsh_pkg.sv
package shabsh_pkg;

    typedef logic [31:0] word_t;
    typedef logic [7:0][31:0] hash_t;

    typedef struct packed {
        logic load;
        logic round;
        logic fold;
        logic init;
    } core_ctl_t;

    localparam logic [1:0] CMD_ABSORB     = 2'd0;
    localparam logic [1:0] CMD_ABSORB_FIN = 2'd1;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LAST_POS = 6'd63;
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [5:0] LAST_RND = 6'd63;
    localparam logic [1:0] LAST_IDX = 2'd3;

    localparam hash_t IV = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    function automatic word_t rotr(input word_t x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic word_t big_sigma0(input word_t x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic word_t round_k(input logic [5:0] i);
        case (i)
            6'd0:  round_k = 32'h428a2f98;
            6'd1:  round_k = 32'h71374491;
            6'd2:  round_k = 32'hb5c0fbcf;
            6'd3:  round_k = 32'he9b5dba5;
            6'd4:  round_k = 32'h3956c25b;
            6'd5:  round_k = 32'h59f111f1;
            6'd6:  round_k = 32'h923f82a4;
            6'd7:  round_k = 32'hab1c5ed5;
            6'd8:  round_k = 32'hd807aa98;
            6'd9:  round_k = 32'h12835b01;
            6'd10: round_k = 32'h243185be;
            6'd11: round_k = 32'h550c7dc3;
            6'd12: round_k = 32'h72be5d74;
            6'd13: round_k = 32'h80deb1fe;
            6'd14: round_k = 32'h9bdc06a7;
            6'd15: round_k = 32'hc19bf174;
            6'd16: round_k = 32'he49b69c1;
            6'd17: round_k = 32'hefbe4786;
            6'd18: round_k = 32'h0fc19dc6;
            6'd19: round_k = 32'h240ca1cc;
            6'd20: round_k = 32'h2de92c6f;
            6'd21: round_k = 32'h4a7484aa;
            6'd22: round_k = 32'h5cb0a9dc;
            6'd23: round_k = 32'h76f988da;
            6'd24: round_k = 32'h983e5152;
            6'd25: round_k = 32'ha831c66d;
            6'd26: round_k = 32'hb00327c8;
            6'd27: round_k = 32'hbf597fc7;
            6'd28: round_k = 32'hc6e00bf3;
            6'd29: round_k = 32'hd5a79147;
            6'd30: round_k = 32'h06ca6351;
            6'd31: round_k = 32'h14292967;
            6'd32: round_k = 32'h27b70a85;
            6'd33: round_k = 32'h2e1b2138;
            6'd34: round_k = 32'h4d2c6dfc;
            6'd35: round_k = 32'h53380d13;
            6'd36: round_k = 32'h650a7354;
            6'd37: round_k = 32'h766a0abb;
            6'd38: round_k = 32'h81c2c92e;
            6'd39: round_k = 32'h92722c85;
            6'd40: round_k = 32'ha2bfe8a1;
            6'd41: round_k = 32'ha81a664b;
            6'd42: round_k = 32'hc24b8b70;
            6'd43: round_k = 32'hc76c51a3;
            6'd44: round_k = 32'hd192e819;
            6'd45: round_k = 32'hd6990624;
            6'd46: round_k = 32'hf40e3585;
            6'd47: round_k = 32'h106aa070;
            6'd48: round_k = 32'h19a4c116;
            6'd49: round_k = 32'h1e376c08;
            6'd50: round_k = 32'h2748774c;
            6'd51: round_k = 32'h34b0bcb5;
            6'd52: round_k = 32'h391c0cb3;
            6'd53: round_k = 32'h4ed8aa4a;
            6'd54: round_k = 32'h5b9cca4f;
            6'd55: round_k = 32'h682e6ff3;
            6'd56: round_k = 32'h748f82ee;
            6'd57: round_k = 32'h78a5636f;
            6'd58: round_k = 32'h84c87814;
            6'd59: round_k = 32'h8cc70208;
            6'd60: round_k = 32'h90befffa;
            6'd61: round_k = 32'ha4506ceb;
            6'd62: round_k = 32'hbef9a3f7;
            6'd63: round_k = 32'hc67178f2;
            default: round_k = 32'h0;
        endcase
    endfunction

endpackage

// File: src/shabsh_msg.sv
module shabsh_msg
    import shabsh_pkg::*;
(
    input  logic        clk,
    input  logic        shift_en,
    input  logic [7:0]  byte_in,
    input  logic        round_en,
    output word_t       w_top
);

    // Window of 16 schedule words; word 0 (oldest) sits in the top bits.
    logic [511:0] blk_reg;
    logic [511:0] blk_next;
    word_t        w_new;

    function automatic word_t win(input logic [511:0] b, input int unsigned j);
        win = b[511 - 32 * j -: 32];
    endfunction

    always_comb
    begin
        w_new = small_sigma1(win(blk_reg, 14)) + win(blk_reg, 9)
              + small_sigma0(win(blk_reg, 1)) + win(blk_reg, 0);
        blk_next = blk_reg;
        if (round_en)
        begin
            blk_next = {blk_reg[479:0], w_new};
        end
        else if (shift_en)
        begin
            blk_next = {blk_reg[503:0], byte_in};
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
    end

    assign w_top = win(blk_reg, 0);

endmodule

// File: src/shabsh_core.sv
module shabsh_core
    import shabsh_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  core_ctl_t  ctl,
    input  word_t      w_in,
    input  logic [5:0] rnd,
    output hash_t      chain
);

    hash_t chain_reg;
    hash_t chain_next;
    hash_t work_reg;
    hash_t work_next;
    word_t t1;
    word_t t2;
    word_t ch;
    word_t maj;

    always_comb
    begin
        ch  = (work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]);
        maj = (work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
            ^ (work_reg[1] & work_reg[2]);
        t1  = work_reg[7] + big_sigma1(work_reg[4]) + ch + round_k(rnd) + w_in;
        t2  = big_sigma0(work_reg[0]) + maj;

        work_next = work_reg;
        if (ctl.load)
        begin
            work_next = chain_reg;
        end
        else if (ctl.round)
        begin
            work_next[7] = work_reg[6];
            work_next[6] = work_reg[5];
            work_next[5] = work_reg[4];
            work_next[4] = work_reg[3] + t1;
            work_next[3] = work_reg[2];
            work_next[2] = work_reg[1];
            work_next[1] = work_reg[0];
            work_next[0] = t1 + t2;
        end

        chain_next = chain_reg;
        if (ctl.init)
        begin
            chain_next = IV;
        end
        else if (ctl.fold)
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_next[i] = chain_reg[i] + work_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg <= IV;
        end
        else
        begin
            chain_reg <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
    end

    assign chain = chain_reg;

endmodule

// File: src/sha256_byte_stream_hasher_unit.sv
// Channel   Dir  tdata                     tuser           tlast
// s_*       in   [7:0] data_byte           [1:0] cmd       -
// m_*       out  [63:0] digest_word        [1:0] word_index last_word
//
// A byte that does not complete a 64-byte block leaves the unit idle and ready for the next byte.
// A byte that completes a block also loads the core, which then runs 64 rounds and one fold.
// Finish shifts padding bytes in one per cycle, the last one also loading the
// core, then compresses once or twice (64 rounds and one fold each), then presents four beats.
// Reset loads the initial hash values and clears the byte count.
// s_tready is high only when idle: it is low while a block is padded or compressed and, after a finish,
// until the last digest beat is taken; m_tready low holds the current beat.
module sha256_byte_stream_hasher_unit
    import shabsh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic [1:0]  s_tuser,    // [1:0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // [63:0] digest_word
    output logic [1:0]  m_tuser,    // [1:0] word_index
    output logic        m_tlast     // last_word
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PAD  = 3'd1;
    localparam logic [2:0] ST_COMP = 3'd2;
    localparam logic [2:0] ST_FOLD = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [60:0] count_reg, count_next;
    logic [5:0]  pos_reg, pos_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic [1:0]  oidx_reg, oidx_next;
    logic        fin_reg, fin_next;
    logic        first_reg, first_next;
    logic        ext_reg, ext_next;
    logic        done_reg, done_next;

    logic        acc;
    logic        take_byte;
    logic        fin_cmd;
    logic        shift_en;
    logic [7:0]  byte_in;
    logic [7:0]  pad_byte;
    logic [63:0] len_bits;
    logic [2:0]  len_sel;
    core_ctl_t   ctl;
    word_t       w_top;
    hash_t       chain;

    assign s_tready  = (state_reg == ST_IDLE);
    assign acc       = s_tvalid && s_tready;
    assign take_byte = acc && (s_tuser inside {CMD_ABSORB, CMD_ABSORB_FIN});
    assign fin_cmd   = acc && (s_tuser != CMD_ABSORB);

    assign len_bits = {count_reg, 3'b000};
    assign len_sel  = ~pos_reg[2:0];

    always_comb
    begin
        if (first_reg)
        begin
            pad_byte = PAD_BYTE;
        end
        else if (pos_reg >= LEN_POS && !ext_reg)
        begin
            pad_byte = len_bits[{len_sel, 3'b000} +: 8];
        end
        else
        begin
            pad_byte = 8'h00;
        end
    end

    assign shift_en = take_byte || (state_reg == ST_PAD);
    assign byte_in  = (state_reg == ST_PAD) ? pad_byte : s_tdata;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        rnd_next   = rnd_reg;
        oidx_next  = oidx_reg;
        fin_next   = fin_reg;
        first_next = first_reg;
        ext_next   = ext_reg;
        done_next  = done_reg;
        ctl        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    fin_next   = fin_cmd;
                    first_next = 1'b1;
                    ext_next   = 1'b0;
                    done_next  = 1'b0;
                    if (take_byte)
                    begin
                        pos_next   = pos_reg + 6'd1;
                        count_next = count_reg + 61'd1;
                        if (pos_reg == LAST_POS)
                        begin
                            ctl.load   = 1'b1;
                            state_next = ST_COMP;
                        end
                        else if (fin_cmd)
                        begin
                            state_next = ST_PAD;
                        end
                    end
                    else
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                pos_next = pos_reg + 6'd1;
                if (first_reg)
                begin
                    first_next = 1'b0;
                    ext_next   = (pos_reg >= LEN_POS);
                end
                if (pos_reg == LAST_POS)
                begin
                    // block carries the length unless the marker landed in its tail
                    done_next  = !(ext_reg || (first_reg && pos_reg >= LEN_POS));
                    ctl.load   = 1'b1;
                    state_next = ST_COMP;
                end
            end
            ST_COMP:
            begin
                ctl.round = 1'b1;
                rnd_next  = rnd_reg + 6'd1;
                if (rnd_reg == LAST_RND)
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                ctl.fold = 1'b1;
                ext_next = 1'b0;
                if (!fin_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (done_reg)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_PAD;
                end
            end
            ST_OUT:
            begin
                if (m_tready)
                begin
                    oidx_next = oidx_reg + 2'd1;
                    if (oidx_reg == LAST_IDX)
                    begin
                        ctl.init   = 1'b1;
                        count_next = '0;
                        fin_next   = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            pos_reg   <= '0;
            rnd_reg   <= '0;
            oidx_reg  <= '0;
            fin_reg   <= 1'b0;
            first_reg <= 1'b0;
            ext_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pos_reg   <= pos_next;
            rnd_reg   <= rnd_next;
            oidx_reg  <= oidx_next;
            fin_reg   <= fin_next;
            first_reg <= first_next;
            ext_reg   <= ext_next;
            done_reg  <= done_next;
        end
    end

    shabsh_msg u_msg
    (
        .clk      (clk),
        .shift_en (shift_en),
        .byte_in  (byte_in),
        .round_en (ctl.round),
        .w_top    (w_top)
    );

    shabsh_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .w_in  (w_top),
        .rnd   (rnd_reg),
        .chain (chain)
    );

    always_comb
    begin
        case (oidx_reg)
            2'd0:    m_tdata = {chain[0], chain[1]};
            2'd1:    m_tdata = {chain[2], chain[3]};
            2'd2:    m_tdata = {chain[4], chain[5]};
            default: m_tdata = {chain[6], chain[7]};
        endcase
    end

    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tuser  = oidx_reg;
    assign m_tlast  = (oidx_reg == LAST_IDX);

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input ready while digest beat pending");

    a_fold_after_rounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMP && rnd_reg == LAST_RND) |=> (state_reg == ST_FOLD))
        else $error("fold did not follow last round");

    a_reinit: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> (count_reg == '0 && pos_reg == '0
            && state_reg == ST_IDLE))
        else $error("state not reinitialized after digest");

    a_out_block_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) |-> (pos_reg == '0 && rnd_reg == '0))
        else $error("digest emitted with partial block");

endmodule
